[design/track_point_interpolator_assert.svh]
// ----------------------------------------------------------------------------
// Track point interpolator assertion macros
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRACK_POINT_INTERPOLATOR_ASSERT_SVH
`define TRACK_POINT_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication.
`define TPI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TPI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/tpi_pkg.sv]
// ----------------------------------------------------------------------------
// Track point interpolator package
// Widths, table entry layout, codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package tpi_pkg;

	localparam int MAX_POINTS = 256;
	localparam int AW         = $clog2(MAX_POINTS);
	localparam int CW         = AW + 1;
	localparam int TS_W       = 48;
	localparam int LAT_W      = 31;
	localparam int LON_W      = 32;
	localparam int CRD_W      = 32;
	localparam int MAG_W      = 34;
	localparam int REM_W      = TS_W + 2;
	localparam int BIT_W      = $clog2(MAG_W);

	// One stored track point.
	typedef struct packed {
		logic [TS_W-1:0]         ts;
		logic signed [CRD_W-1:0] lat;
		logic signed [CRD_W-1:0] lon;
		logic                    act;
	} entry_t;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_FULL   = 2'd1,
		ST_POS    = 2'd2,
		ST_NOPOS  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SRCH,
		S_SRCH_CMP,
		S_RD_P,
		S_CAP_P,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WRITE,
		S_RD_A,
		S_CAP_A,
		S_CHK_A,
		S_DIV_ADD,
		S_DIV_SUB1,
		S_DIV_SUB2,
		S_DIV_FIN,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    srch_rd;
		logic    srch_upd;
		logic    rd_p;
		logic    cap_p;
		logic    rd_a;
		logic    cap_a;
		logic    shift_init;
		logic    shift_rd;
		logic    shift_wr;
		logic    write_item;
		logic    res_en;
		status_t res_code;
		logic    give_p;
		logic    div_init_lat;
		logic    div_init_lon;
		logic    div_add;
		logic    div_sub;
		logic    div_next;
		logic    fin_lat;
		logic    fin_lon;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_query;
		logic lo_lt_hi;
		logic p_lt_count;
		logic match;
		logic full;
		logic p_gt0;
		logic shift_more;
		logic act_p;
		logic act_a;
		logic bit_zero;
		logic out_free;
	} sts_t;

endpackage

[design/tpi_in_if.sv]
// ----------------------------------------------------------------------------
// Track point interpolator request channel
// Valid/ready channel carrying one add or query item.
// ----------------------------------------------------------------------------
interface tpi_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [47:0]        timestamp;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic               point_valid;

	modport source (output valid, kind, timestamp, latitude, longitude, point_valid,
		input ready);
	modport sink (input valid, kind, timestamp, latitude, longitude, point_valid,
		output ready);
endinterface

interface tpi_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [30:0] out_latitude;
	logic signed [31:0] out_longitude;

	modport source (output valid, status, out_latitude, out_longitude, input ready);
	modport sink (input valid, status, out_latitude, out_longitude, output ready);
endinterface

[design/tpi_ctrl.sv]
// ----------------------------------------------------------------------------
// Track point interpolator controller
// Sequences search, insertion shift, lookup and the serial divider.
// ----------------------------------------------------------------------------
module tpi_ctrl
	import tpi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   coord_q, coord_d;

	// State register; coord_q marks the longitude pass of the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			coord_q <= 1'b0;
		end else begin
			state_q <= state_d;
			coord_q <= coord_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		coord_d = coord_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SRCH;
			end
			S_SRCH:     state_d = sts.lo_lt_hi ? S_SRCH_CMP : S_RD_P;
			S_SRCH_CMP: state_d = S_SRCH;
			S_RD_P:     state_d = S_CAP_P;
			S_CAP_P:    state_d = S_DECIDE;
			S_DECIDE: begin
				if (!sts.is_query) begin
					if (sts.match) state_d = S_WRITE;
					else if (sts.full) state_d = S_DONE;
					else state_d = S_SHIFT_RD;
				end else if (sts.match) begin
					state_d = S_DONE;
				end else if (sts.p_gt0 && sts.p_lt_count) begin
					state_d = S_RD_A;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHIFT_RD: state_d = sts.shift_more ? S_SHIFT_WR : S_WRITE;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_WRITE:    state_d = S_DONE;
			S_RD_A:     state_d = S_CAP_A;
			S_CAP_A:    state_d = S_CHK_A;
			S_CHK_A: begin
				coord_d = 1'b0;
				state_d = (sts.act_p && sts.act_a) ? S_DIV_ADD : S_DONE;
			end
			S_DIV_ADD:  state_d = S_DIV_SUB1;
			S_DIV_SUB1: state_d = S_DIV_SUB2;
			S_DIV_SUB2: state_d = sts.bit_zero ? S_DIV_FIN : S_DIV_ADD;
			S_DIV_FIN: begin
				if (!coord_q) begin
					coord_d = 1'b1;
					state_d = S_DIV_ADD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// Command outputs.
	always_comb begin
		cmd = '0;
		cmd.res_code = ST_STORED;
		unique case (state_q)
			S_IDLE:     cmd.load = in_valid;
			S_SRCH:     cmd.srch_rd = sts.lo_lt_hi;
			S_SRCH_CMP: cmd.srch_upd = 1'b1;
			S_RD_P:     cmd.rd_p = 1'b1;
			S_CAP_P:    cmd.cap_p = 1'b1;
			S_DECIDE: begin
				if (!sts.is_query) begin
					if (!sts.match && sts.full) begin
						cmd.res_en   = 1'b1;
						cmd.res_code = ST_FULL;
					end else if (!sts.match) begin
						cmd.shift_init = 1'b1;
					end
				end else if (sts.match) begin
					cmd.res_en   = 1'b1;
					cmd.res_code = sts.act_p ? ST_POS : ST_NOPOS;
					cmd.give_p   = sts.act_p;
				end else if (!(sts.p_gt0 && sts.p_lt_count)) begin
					cmd.res_en   = 1'b1;
					cmd.res_code = ST_NOPOS;
				end
			end
			S_SHIFT_RD: cmd.shift_rd = sts.shift_more;
			S_SHIFT_WR: cmd.shift_wr = 1'b1;
			S_WRITE: begin
				cmd.write_item = 1'b1;
				cmd.res_en     = 1'b1;
				cmd.res_code   = ST_STORED;
			end
			S_RD_A:  cmd.rd_a = 1'b1;
			S_CAP_A: cmd.cap_a = 1'b1;
			S_CHK_A: begin
				if (sts.act_p && sts.act_a) begin
					cmd.div_init_lat = 1'b1;
				end else begin
					cmd.res_en   = 1'b1;
					cmd.res_code = ST_NOPOS;
				end
			end
			S_DIV_ADD:  cmd.div_add = 1'b1;
			S_DIV_SUB1: cmd.div_sub = 1'b1;
			S_DIV_SUB2: begin
				cmd.div_sub  = 1'b1;
				cmd.div_next = !sts.bit_zero;
			end
			S_DIV_FIN: begin
				if (!coord_q) begin
					cmd.fin_lat      = 1'b1;
					cmd.div_init_lon = 1'b1;
				end else begin
					cmd.fin_lon  = 1'b1;
					cmd.res_en   = 1'b1;
					cmd.res_code = ST_POS;
				end
			end
			S_DONE:  cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[design/tpi_dp.sv]
// ----------------------------------------------------------------------------
// Track point interpolator datapath
// Point table memory, search bounds, shift pointer, serial divider, result.
// ----------------------------------------------------------------------------
`include "track_point_interpolator_assert.svh"

module tpi_dp
	import tpi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               kind,
	input  logic [TS_W-1:0]    timestamp,
	input  logic signed [LAT_W-1:0] latitude,
	input  logic signed [LON_W-1:0] longitude,
	input  logic               point_valid,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_status,
	output logic signed [LAT_W-1:0] out_lat,
	output logic signed [LON_W-1:0] out_lon
);

	entry_t          mem_q [MAX_POINTS];
	entry_t          rd_data_q;
	entry_t          item_q;
	entry_t          ent_p_q, ent_a_q;
	logic            kind_q;
	logic [CW-1:0]   lo_q, hi_q, mid_q, count_q, ptr_q;
	logic [CW-1:0]   mid_c, lo_m1, ptr_m1;
	logic            re, we;
	logic [AW-1:0]   ra, wa;
	entry_t          wd;
	logic            match_c, out_free;
	logic [TS_W-1:0] num_q, den_q;
	logic [REM_W-1:0] r_q, r_add, den_ext;
	logic [MAG_W-1:0] q_q, m_q, res_sum;
	logic signed [MAG_W-1:0] diff_c;
	logic signed [CRD_W-1:0] base_q, coord_a, coord_b;
	logic            neg_q;
	logic [BIT_W-1:0] bit_q;
	status_t         res_code_q;
	logic signed [LAT_W-1:0] res_lat_q;
	logic signed [LON_W-1:0] res_lon_q;
	logic            out_valid_q;
	logic [1:0]      out_status_q;
	logic signed [LAT_W-1:0] out_lat_q;
	logic signed [LON_W-1:0] out_lon_q;

	assign mid_c   = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_m1   = lo_q - 1'b1;
	assign ptr_m1  = ptr_q - 1'b1;
	assign match_c = (lo_q < count_q) && (ent_p_q.ts == item_q.ts);
	assign out_free = !out_valid_q || out_ready;
	assign den_ext = {2'b00, den_q};

	// Memory port selection.
	always_comb begin
		re = cmd.srch_rd || cmd.rd_p || cmd.rd_a || cmd.shift_rd;
		ra = ptr_m1[AW-1:0];
		if (cmd.srch_rd) ra = mid_c[AW-1:0];
		else if (cmd.rd_p) ra = lo_q[AW-1:0];
		else if (cmd.rd_a) ra = lo_m1[AW-1:0];
		we = cmd.shift_wr || cmd.write_item;
		wa = cmd.shift_wr ? ptr_q[AW-1:0] : lo_q[AW-1:0];
		wd = cmd.shift_wr ? rd_data_q : item_q;
	end

	// Point table.
	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		if (re) rd_data_q <= mem_q[ra];
	end

	// Item capture, search bounds, fill count and shift pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.load) begin
				lo_q <= '0;
				hi_q <= count_q;
			end
			if (cmd.srch_upd) begin
				if (rd_data_q.ts < item_q.ts) lo_q <= mid_q + 1'b1;
				else hi_q <= mid_q;
			end
			if (cmd.shift_init) ptr_q <= count_q;
			if (cmd.shift_wr) ptr_q <= ptr_m1;
			if (cmd.write_item && !match_c) count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= kind;
			item_q.ts  <= timestamp;
			item_q.lat <= CRD_W'(latitude);
			item_q.lon <= CRD_W'(longitude);
			item_q.act <= point_valid;
		end
		if (cmd.srch_rd) mid_q <= mid_c;
		if (cmd.cap_p) ent_p_q <= rd_data_q;
		if (cmd.cap_a) ent_a_q <= rd_data_q;
	end

	// Divider operand selection: latitude pass, then longitude pass.
	always_comb begin
		coord_a = cmd.div_init_lon ? ent_a_q.lon : ent_a_q.lat;
		coord_b = cmd.div_init_lon ? ent_p_q.lon : ent_p_q.lat;
		diff_c  = MAG_W'(coord_b) - MAG_W'(coord_a);
		r_add   = {r_q[REM_W-2:0], 1'b0} + (m_q[bit_q] ? {2'b00, num_q} : '0);
		res_sum = neg_q ? MAG_W'(base_q) - q_q : MAG_W'(base_q) + q_q;
	end

	// Serial (m * num) / den, one multiplier bit per add step and two subtract steps.
	always_ff @(posedge clk) begin
		if (cmd.div_init_lat) begin
			num_q <= item_q.ts - ent_a_q.ts;
			den_q <= ent_p_q.ts - ent_a_q.ts;
		end
		if (cmd.div_init_lat || cmd.div_init_lon) begin
			base_q <= coord_a;
			neg_q  <= diff_c[MAG_W-1];
			m_q    <= diff_c[MAG_W-1] ? -diff_c : diff_c;
			r_q    <= '0;
			q_q    <= '0;
			bit_q  <= BIT_W'(MAG_W - 1);
		end
		if (cmd.div_add) begin
			r_q <= r_add;
			q_q <= {q_q[MAG_W-2:0], 1'b0};
		end
		if (cmd.div_sub && (r_q >= den_ext)) begin
			r_q <= r_q - den_ext;
			q_q <= q_q + 1'b1;
		end
		if (cmd.div_next) bit_q <= bit_q - 1'b1;
	end

	// Result assembly; coordinates stay zero unless a position is given.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_lat_q <= '0;
			res_lon_q <= '0;
		end
		if (cmd.res_en) res_code_q <= cmd.res_code;
		if (cmd.give_p) begin
			res_lat_q <= ent_p_q.lat[LAT_W-1:0];
			res_lon_q <= ent_p_q.lon[LON_W-1:0];
		end
		if (cmd.fin_lat) res_lat_q <= res_sum[LAT_W-1:0];
		if (cmd.fin_lon) res_lon_q <= res_sum[LON_W-1:0];
	end

	// Output register; holds a transaction while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_code_q;
			out_lat_q    <= res_lat_q;
			out_lon_q    <= res_lon_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_lat    = out_lat_q;
	assign out_lon    = out_lon_q;

	// Status back to the controller.
	always_comb begin
		sts.is_query   = kind_q;
		sts.lo_lt_hi   = lo_q < hi_q;
		sts.p_lt_count = lo_q < count_q;
		sts.match      = match_c;
		sts.full       = count_q == CW'(MAX_POINTS);
		sts.p_gt0      = lo_q != '0;
		sts.shift_more = ptr_q > lo_q;
		sts.act_p      = ent_p_q.act;
		sts.act_a      = ent_a_q.act;
		sts.bit_zero   = bit_q == '0;
		sts.out_free   = out_free;
	end

	`TPI_ASSERT_IMP(a_out_slot, cmd.out_load, out_free, "result overwrote a pending transaction")
	`TPI_ASSERT_IMP(a_shift_range, cmd.shift_wr, (ptr_q > lo_q) && (ptr_q <= count_q), "bad shift")
	`TPI_ASSERT_NXT(a_count_grow, cmd.write_item && !match_c, count_q == $past(count_q) + 1'b1, "no grow")
	`TPI_ASSERT_IMP(a_rem_norm, cmd.fin_lat || cmd.fin_lon, r_q < den_ext, "remainder not reduced")

endmodule

[design/track_point_interpolator.sv]
// ----------------------------------------------------------------------------
// Track point interpolator
// Time-sorted track point table with exact lookup and linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
// req carries one add (kind 0) or query (kind 1) transaction; rsp returns
// exactly one result transaction per request, in order.
// One item is worked on at a time; req.ready is high only while idle.
// Flow, with every table read through the single read port: a binary search
// that reads and compares one probe at a time, then a fetch of the located point.
// An add that replaces or is dropped then finishes; a new point first
// shifts each entry above it up one slot, reading and writing each back.
// An exact-match query finishes at once; an interpolation fetches the lower
// point and runs the serial divider, one multiplier bit at a time (an add
// step, then two subtract steps), 34 bits each for latitude and longitude.
// The result sits in an output register; the next request is accepted while
// it waits, and only its completion stalls until rsp.ready frees the slot.
// Reset empties the table (fill count zero) and clears all handshakes; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module track_point_interpolator
	import tpi_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	tpi_in_if.sink  req,
	tpi_out_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	tpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table and arithmetic.
	tpi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (req.kind),
		.timestamp   (req.timestamp),
		.latitude    (req.latitude),
		.longitude   (req.longitude),
		.point_valid (req.point_valid),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_status  (rsp.status),
		.out_lat     (rsp.out_latitude),
		.out_lon     (rsp.out_longitude)
	);

endmodule
